// File: hdl/text_console_renderer_unit_macros.svh
// Assertion macros for the text console renderer checker.
// Each macro expands to one labeled concurrent assertion with a reset guard.
`ifndef TEXT_CONSOLE_RENDERER_UNIT_MACROS_SVH
`define TEXT_CONSOLE_RENDERER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/tcr_pkg.sv
// Shared types and codes of the text console renderer.
// Used by the top level, the address unit and the checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tcr_pkg;

  localparam int ADDR_W      = 20;
  localparam int GLYPH_W     = 64;
  localparam int COLOR_W     = 32;
  localparam int COL_W       = 7;
  localparam int ROW_W       = 6;
  localparam int GLYPH_COUNT = 256;
  localparam int CODE_W      = 8;

  // Operation codes of an input word.
  localparam logic [1:0] OP_PRINT  = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_CURSOR = 2'd2;
  localparam logic [1:0] OP_SCREEN = 2'd3;

  // Command kinds of a result word.
  localparam logic [1:0] KIND_CELL   = 2'd0;
  localparam logic [1:0] KIND_ROW    = 2'd1;
  localparam logic [1:0] KIND_SCREEN = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TEXT_COLOR   = 2'd0;
  localparam logic [1:0] CFG_BACK_COLOR   = 2'd1;
  localparam logic [1:0] CFG_CLEAR_COLOR  = 2'd2;
  localparam logic [1:0] CFG_FRAME_OFFSET = 2'd3;

  // Control characters and the glyph a tab draws.
  localparam logic [CODE_W-1:0] CODE_TAB     = 8'd9;
  localparam logic [CODE_W-1:0] CODE_NEWLINE = 8'd10;
  localparam logic [CODE_W-1:0] CODE_SPACE   = 8'd32;

  // Most cells that one tab may draw.
  localparam logic [5:0] MAX_TAB_DRAWS = 6'd32;

  typedef struct packed {
    logic [1:0]         op;
    logic [CODE_W-1:0]  char_code;
    logic [GLYPH_W-1:0] glyph_bits;
    logic [COL_W-1:0]   cursor_col;
    logic [ROW_W-1:0]   cursor_row;
    logic               last_char;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [ADDR_W-1:0]  word_address;
    logic [GLYPH_W-1:0] glyph_pattern;
    logic [COLOR_W-1:0] paint_color;
    logic [COL_W-1:0]   column_now;
    logic [ROW_W-1:0]   row_now;
    logic               last;
  } out_word_t;

  // Control from the sequencer to the address unit.
  typedef struct packed {
    logic             mul_en;
    logic [ROW_W-1:0] mul_row;
    logic [COL_W-1:0] col;
  } agu_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/text_console_renderer_unit.sv
// Top level of the text console renderer: sequencer, cursor, configuration and output register.
// Depends on tcr_pkg, tcr_ram (glyph store) and tcr_agu (address unit).
`timescale 1ns / 1ps
`default_nettype none

// Usage
// Input words arrive on in_valid/in_word and are taken at an edge where in_stall is low.
// Each word is one console operation: print a character, load a glyph, set the cursor or
// clear the screen. Result words leave on out_valid/out_word and are taken at an edge where
// out_stall is low. Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high and writes should only be made while the block is idle.
// Loading a glyph or setting the cursor is finished at the accepting edge and the block is
// ready again in the next cycle. A printed character passes through the multiply state, then
// the draw state loads the output register; a wrap to a new row adds a multiply and a row clear.
// A newline or a screen clear passes the multiply and clear states. A tab passes the multiply
// state and then draws up to 32 cells. The order is set by the shared address unit: each text
// row needs one registered multiply before its first address; the address adder is combinational.
// While an operation is in progress in_stall stays high. A one-word output register parts
// the channels, so the next operation can be accepted while the last result is still waiting.
// When the receiver stalls, the output word holds and the sequencer waits in place.
// Reset (rst_n low, synchronous) clears the cursor, the colors, the frame offset and the
// output valid; the glyph store is not cleared and a glyph must be loaded before it is used.

module text_console_renderer_unit #(
  parameter int COLUMNS    = 68,
  parameter int ROWS       = 34,
  parameter int TAB_STOP   = 32,
  parameter int LINE_PITCH = 512
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_stall,
  input  wire tcr_pkg::in_word_t   in_word,
  output      logic                out_valid,
  input  wire logic                out_stall,
  output      tcr_pkg::out_word_t  out_word,
  input  wire logic                cfg_valid,
  output      logic                cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [31:0]         cfg_data
);
  import tcr_pkg::*;

  // A tab never goes past the last column.
  localparam int TAB_LIMIT = (TAB_STOP > COLUMNS - 1) ? COLUMNS - 1 : TAB_STOP;

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DRAW = 2'd2;
  localparam logic [1:0] S_CLR  = 2'd3;

  logic [1:0]         state_r,      state_nxt;
  logic [COL_W-1:0]   cur_col_r,    cur_col_nxt;
  logic [ROW_W-1:0]   cur_row_r,    cur_row_nxt;
  logic [COL_W-1:0]   dcol_r,       dcol_nxt;
  logic [ROW_W-1:0]   mrow_r,       mrow_nxt;
  logic [5:0]         draws_left_r, draws_left_nxt;
  logic               clr_pend_r,   clr_pend_nxt;
  logic [1:0]         clr_kind_r,   clr_kind_nxt;
  logic [ROW_W-1:0]   clr_row_r,    clr_row_nxt;
  logic               out_valid_r,  out_valid_nxt;
  out_word_t          out_word_r,   out_word_nxt;

  logic [COLOR_W-1:0] text_color_r;
  logic [COLOR_W-1:0] clear_color_r;
  logic [18:0]        base_r;

  logic               in_accept;
  logic               out_free;
  logic [7:0]         col_inc;
  logic [6:0]         row_inc;
  logic [ROW_W-1:0]   row_next;
  logic [COL_W-1:0]   tab_span;
  logic [5:0]         tab_cnt;
  logic               ram_we;
  logic               ram_re;
  logic [CODE_W-1:0]  ram_raddr;
  logic [GLYPH_W-1:0] glyph;
  agu_ctrl_t          agu_ctrl;
  logic [ADDR_W-1:0]  agu_addr;
  logic [ADDR_W-1:0]  base_word;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign cfg_ready = 1'b1;
  assign base_word = {1'b0, base_r};

  // Cursor arithmetic for the operation being accepted.
  assign col_inc  = {1'b0, cur_col_r} + 8'd1;
  assign row_inc  = {1'b0, cur_row_r} + 7'd1;
  assign row_next = (row_inc >= 7'(ROWS)) ? '0 : row_inc[ROW_W-1:0];
  assign tab_span = 7'(TAB_LIMIT) - cur_col_r;
  assign tab_cnt  = (tab_span > 7'(MAX_TAB_DRAWS)) ? MAX_TAB_DRAWS : tab_span[5:0];

  // The glyph is read at the accepting edge and stays on the RAM output until the next read.
  assign ram_we    = in_accept && (in_word.op == OP_LOAD);
  assign ram_re    = in_accept && (in_word.op == OP_PRINT);
  assign ram_raddr = (in_word.char_code == CODE_TAB) ? CODE_SPACE : in_word.char_code;

  tcr_ram #(
    .WIDTH (GLYPH_W),
    .DEPTH (GLYPH_COUNT)
  ) u_glyph_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_word.char_code),
    .wdata (in_word.glyph_bits),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (glyph)
  );

  // Row clears address column zero; only cell draws add the column offset.
  assign agu_ctrl.mul_en  = (state_r == S_MUL);
  assign agu_ctrl.mul_row = mrow_r;
  assign agu_ctrl.col     = (state_r == S_DRAW) ? dcol_r : '0;

  tcr_agu #(
    .LINE_PITCH (LINE_PITCH)
  ) u_agu (
    .clk  (clk),
    .ctrl (agu_ctrl),
    .base (base_word),
    .addr (agu_addr)
  );

  always_comb begin
    state_nxt      = state_r;
    cur_col_nxt    = cur_col_r;
    cur_row_nxt    = cur_row_r;
    dcol_nxt       = dcol_r;
    mrow_nxt       = mrow_r;
    draws_left_nxt = draws_left_r;
    clr_pend_nxt   = clr_pend_r;
    clr_kind_nxt   = clr_kind_r;
    clr_row_nxt    = clr_row_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_word_nxt   = out_word_r;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          case (in_word.op)
            OP_PRINT: begin
              if (in_word.char_code == CODE_NEWLINE) begin
                cur_col_nxt    = '0;
                cur_row_nxt    = row_next;
                draws_left_nxt = '0;
                clr_pend_nxt   = 1'b1;
                clr_kind_nxt   = KIND_ROW;
                clr_row_nxt    = row_next;
                mrow_nxt       = row_next;
                state_nxt      = S_MUL;
              end else if (in_word.char_code == CODE_TAB) begin
                // At or past the stop a tab does nothing.
                if (cur_col_r < 7'(TAB_LIMIT)) begin
                  cur_col_nxt    = cur_col_r + 7'(tab_cnt);
                  dcol_nxt       = cur_col_r;
                  mrow_nxt       = cur_row_r;
                  draws_left_nxt = tab_cnt;
                  clr_pend_nxt   = 1'b0;
                  state_nxt      = S_MUL;
                end
              end else begin
                dcol_nxt       = cur_col_r;
                mrow_nxt       = cur_row_r;
                draws_left_nxt = 6'd1;
                state_nxt      = S_MUL;
                if (col_inc >= 8'(COLUMNS)) begin
                  cur_col_nxt  = '0;
                  cur_row_nxt  = row_next;
                  clr_pend_nxt = 1'b1;
                  clr_kind_nxt = KIND_ROW;
                  clr_row_nxt  = row_next;
                end else begin
                  cur_col_nxt  = col_inc[COL_W-1:0];
                  clr_pend_nxt = 1'b0;
                end
              end
            end
            OP_CURSOR: begin
              if (in_word.cursor_col < 7'(COLUMNS)) begin
                cur_col_nxt = in_word.cursor_col;
              end
              if (in_word.cursor_row < 6'(ROWS)) begin
                cur_row_nxt = in_word.cursor_row;
              end
            end
            OP_SCREEN: begin
              cur_col_nxt    = '0;
              cur_row_nxt    = '0;
              draws_left_nxt = '0;
              clr_pend_nxt   = 1'b1;
              clr_kind_nxt   = KIND_SCREEN;
              mrow_nxt       = '0;
              state_nxt      = S_MUL;
            end
            default: begin
              // A glyph load is done by the RAM write alone.
            end
          endcase
        end
      end
      S_MUL: begin
        state_nxt = (draws_left_r != '0) ? S_DRAW : S_CLR;
      end
      S_DRAW: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_word_nxt.kind          = KIND_CELL;
          out_word_nxt.word_address  = agu_addr;
          out_word_nxt.glyph_pattern = glyph;
          out_word_nxt.paint_color   = text_color_r;
          out_word_nxt.column_now    = cur_col_r;
          out_word_nxt.row_now       = cur_row_r;
          out_word_nxt.last          = (draws_left_r == 6'd1) && !clr_pend_r;
          dcol_nxt                   = dcol_r + 7'd1;
          draws_left_nxt             = draws_left_r - 6'd1;
          if (draws_left_r == 6'd1) begin
            if (clr_pend_r) begin
              mrow_nxt  = clr_row_r;
              state_nxt = S_MUL;
            end else begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      S_CLR: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_word_nxt.kind          = clr_kind_r;
          out_word_nxt.word_address  = agu_addr;
          out_word_nxt.glyph_pattern = '0;
          out_word_nxt.paint_color   = clear_color_r;
          out_word_nxt.column_now    = cur_col_r;
          out_word_nxt.row_now       = cur_row_r;
          out_word_nxt.last          = 1'b1;
          clr_pend_nxt               = 1'b0;
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      clr_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      clr_pend_r  <= clr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dcol_r       <= dcol_nxt;
    mrow_r       <= mrow_nxt;
    draws_left_r <= draws_left_nxt;
    clr_kind_r   <= clr_kind_nxt;
    clr_row_r    <= clr_row_nxt;
    out_word_r   <= out_word_nxt;
  end

  // Configuration registers. The background color is applied by the pixel writer
  // downstream and is not part of any result, so a write to it is taken and dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r  <= '0;
      clear_color_r <= '0;
      base_r        <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TEXT_COLOR:   text_color_r  <= cfg_data;
        CFG_CLEAR_COLOR:  clear_color_r <= cfg_data;
        CFG_FRAME_OFFSET: base_r        <= cfg_data[20:2];
        CFG_BACK_COLOR:   ;
        default:          ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/tcr_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Holds the glyph store; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module tcr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/tcr_agu.sv
// Shared address unit: one registered row multiply and one add of product, cell offset and base.
// Depends on tcr_pkg for widths and the control struct.
`timescale 1ns / 1ps
`default_nettype none

module tcr_agu #(
  parameter int LINE_PITCH = 512
) (
  input  wire logic                      clk,
  input  wire tcr_pkg::agu_ctrl_t        ctrl,
  input  wire logic [tcr_pkg::ADDR_W-1:0] base,
  output      logic [tcr_pkg::ADDR_W-1:0] addr
);
  import tcr_pkg::*;

  // One text row is eight pixel lines of LINE_PITCH words.
  localparam int ROW_STRIDE = 8 * LINE_PITCH;

  logic [ADDR_W-1:0] prod_r;
  logic [ADDR_W-1:0] prod_nxt;
  logic [9:0]        cell_off;

  assign prod_nxt = ADDR_W'(ctrl.mul_row * ROW_STRIDE);

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= prod_nxt;
    end
  end

  // Column times seven, as eight times minus one.
  assign cell_off = {ctrl.col, 3'b000} - {3'b000, ctrl.col};
  assign addr     = base + ADDR_W'(cell_off) + prod_r;

endmodule

`default_nettype wire

// File: hdl/tcr_checker.sv
// Port-level checker of the text console renderer, bound to the top level.
// Depends on tcr_pkg and text_console_renderer_unit_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "text_console_renderer_unit_macros.svh"

module tcr_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire tcr_pkg::in_word_t  in_word,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire tcr_pkg::out_word_t out_word
);
  import tcr_pkg::*;

  // A held result word must not change while the receiver stalls.
  `TCR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_word), "output word changed while stalled")

  // A screen clear always has work left, so the block must be busy next cycle.
  `TCR_ASSERT_NEXT(a_screen_busy, clk, rst_n, in_valid && !in_stall && in_word.op == OP_SCREEN, in_stall, "screen clear accepted without going busy")

  // A screen clear homes the cursor and is the only result of its operation.
  `TCR_ASSERT_SAME(a_screen_home, clk, rst_n, out_valid && out_word.kind == KIND_SCREEN, out_word.column_now == '0 && out_word.row_now == '0 && out_word.last, "screen clear with cursor not at home")

  // A row clear ends its operation and leaves the cursor in column zero.
  `TCR_ASSERT_SAME(a_row_clear_last, clk, rst_n, out_valid && out_word.kind == KIND_ROW, out_word.last && out_word.column_now == '0, "row clear not final or cursor not in column zero")

endmodule

bind text_console_renderer_unit tcr_checker u_tcr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

`default_nettype wire
